FILE: hw/rtl/kbs_pkg.sv
// ----------------------------------------------------------------------------
// kbs_pkg
// Shared types, fixed-point constants and helpers for the Kepler bisection
// solver.
// ----------------------------------------------------------------------------
package kbs_pkg;

	localparam int DEF_GRID_STEPS = 8192;
	localparam int DEF_SINE_BITS  = 30;

	localparam int FW = 36;	// width of a Kepler function value

	localparam logic [29:0] PI_Q28      = 30'd843314856;
	localparam logic [29:0] HALF_PI_Q28 = 30'd421657428;
	localparam logic [30:0] TWO_PI_Q28  = 31'd1686629712;
	localparam logic [30:0] ONE_Q30     = 31'd1073741824;

	localparam logic [27:0] TOL_RESET = 28'd268435;

	localparam int HORNER_STEPS = 6;

	// Exact floor division by the Horner divisors 156, 110, 72, 42, 20 and 6
	// through a reciprocal multiply. The 32-bit dividend never exceeds x^2 at
	// x = pi/2, which stays inside the exact range of every reciprocal.
	localparam logic [63:0] HORNER_RECIP [HORNER_STEPS] = '{
		((64'd1 << 39) + 64'd155) / 64'd156,
		((64'd1 << 38) + 64'd109) / 64'd110,
		((64'd1 << 38) + 64'd71) / 64'd72,
		((64'd1 << 37) + 64'd41) / 64'd42,
		((64'd1 << 36) + 64'd19) / 64'd20,
		((64'd1 << 34) + 64'd5) / 64'd6
	};
	localparam int HORNER_SHIFT [HORNER_STEPS] = '{39, 38, 38, 37, 36, 34};

	typedef enum logic [0:0] {
		CFG_ECC = 1'b0,
		CFG_TOL = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT,
		S_CHECK
	} state_t;

	typedef enum logic [1:0] {
		T_LO,
		T_HI,
		T_MID
	} target_t;

	// Token moving along the cell chain. The squared argument reaches about
	// 2.47 in Q30 near pi/2, so it needs a full 32 bits.
	typedef struct packed {
		logic        valid;
		logic        neg;
		logic [30:0] ang;
		logic [30:0] x;
		logic [31:0] x2;
		logic [30:0] t;
	} tok_t;

	function automatic logic [FW:0] mag_of(input logic signed [FW:0] v);
		logic signed [FW:0] n;
		n = -v;
		return v[FW] ? n : v;
	endfunction

endpackage

FILE: hw/rtl/kbs_front.sv
// ----------------------------------------------------------------------------
// kbs_front
// Grid angle, quadrant reduction and squared argument for the sine series.
// ----------------------------------------------------------------------------
module kbs_front #(
	parameter int GRID_STEPS = kbs_pkg::DEF_GRID_STEPS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [$clog2(GRID_STEPS+1)-1:0] idx,
	output kbs_pkg::tok_t                    tok
);
	localparam int GL = $clog2(GRID_STEPS);
	localparam int IW = $clog2(GRID_STEPS + 1);

	logic [IW+30:0] prod_s1;
	logic           v_s1, v_s2, v_s3;
	logic [30:0]    ang_s2, x_s2, ang_s3, x_s3;
	logic [31:0]    x2_s3;
	logic           neg_s2, neg_s3;
	logic [30:0]    a, a1, a2;
	logic           neg;
	logic [61:0]    sq;

	always_comb begin
		a   = prod_s1[GL+30:GL];
		neg = a > 31'(kbs_pkg::PI_Q28);
		a1  = neg ? a - 31'(kbs_pkg::PI_Q28) : a;
		a2  = (a1 > 31'(kbs_pkg::HALF_PI_Q28)) ? 31'(kbs_pkg::PI_Q28) - a1 : a1;
		sq  = 62'(x_s2) * 62'(x_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= (IW+31)'(idx) * (IW+31)'(kbs_pkg::TWO_PI_Q28);
		ang_s2  <= a;
		neg_s2  <= neg;
		x_s2    <= {a2[28:0], 2'b00};
		ang_s3  <= ang_s2;
		neg_s3  <= neg_s2;
		x_s3    <= x_s2;
		x2_s3   <= sq[61:30];
	end

	assign tok = '{valid: v_s3, neg: neg_s3, ang: ang_s3, x: x_s3, x2: x2_s3,
		t: kbs_pkg::ONE_Q30};
endmodule

FILE: hw/rtl/kbs_cell.sv
// ----------------------------------------------------------------------------
// kbs_cell
// One Horner step of the sine series: t' = 1 - (x^2 * t) / d.
// ----------------------------------------------------------------------------
module kbs_cell #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  kbs_pkg::tok_t tin,
	output kbs_pkg::tok_t tout
);
	localparam logic [63:0] RECIP = kbs_pkg::HORNER_RECIP[STEP];
	localparam int          SH    = kbs_pkg::HORNER_SHIFT[STEP];

	kbs_pkg::tok_t tok_s1, tok_s2;
	logic [61:0]   p_s1;
	logic [63:0]   q;

	assign q = 64'(p_s1[61:30]) * RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_s1   <= '0;
			tok_s1 <= '0;
			tok_s2 <= '0;
		end else begin
			p_s1         <= 62'(tin.x2) * 62'(tin.t);
			tok_s1       <= tin;
			tok_s2.valid <= tok_s1.valid;
			tok_s2.neg   <= tok_s1.neg;
			tok_s2.ang   <= tok_s1.ang;
			tok_s2.x     <= tok_s1.x;
			tok_s2.x2    <= tok_s1.x2;
			tok_s2.t     <= kbs_pkg::ONE_Q30 - 31'(q >> SH);
		end
	end

	assign tout = tok_s2;
endmodule

FILE: hw/rtl/kbs_back.sv
// ----------------------------------------------------------------------------
// kbs_back
// Final sine product, rounding, eccentricity scaling and f(E) = M - E + e*sin E.
// ----------------------------------------------------------------------------
module kbs_back #(
	parameter int SINE_BITS = kbs_pkg::DEF_SINE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kbs_pkg::tok_t                     tin,
	input  logic [15:0]                       ecc,
	input  logic [30:0]                       m,
	output logic                              f_valid,
	output logic signed [kbs_pkg::FW-1:0]     f
);
	localparam int          RS  = 32 - SINE_BITS;
	localparam logic [31:0] RND = (RS > 0) ? 32'(64'd1 << (RS - 1)) : 32'd0;
	localparam int          ESR = (SINE_BITS >= 14) ? SINE_BITS - 14 : 0;
	localparam int          ESL = (SINE_BITS < 14) ? 14 - SINE_BITS : 0;

	logic        v_s1, v_s2, v_s3;
	logic        neg_s1, neg_s2;
	logic [30:0] ang_s1, ang_s2;
	logic [30:0] y_s1;
	logic [46:0] mag_s2;
	logic [61:0] yp;
	logic [31:0] sr;
	logic [48:0] es_w;
	logic signed [kbs_pkg::FW-1:0] es;

	always_comb begin
		yp   = 62'(tin.x) * 62'(tin.t);
		sr   = (32'(y_s1) + RND) >> RS;
		es_w = (49'(mag_s2) << ESL) >> ESR;
		es   = neg_s2 ? -$signed(kbs_pkg::FW'(es_w[31:0])) : $signed(kbs_pkg::FW'(es_w[31:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= tin.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		y_s1   <= yp[60:30];
		neg_s1 <= tin.neg;
		ang_s1 <= tin.ang;
		mag_s2 <= 47'(ecc) * 47'(sr[30:0]);
		neg_s2 <= neg_s1;
		ang_s2 <= ang_s1;
		f      <= $signed(kbs_pkg::FW'(m)) - $signed(kbs_pkg::FW'(ang_s2)) + es;
	end

	assign f_valid = v_s3;
endmodule

FILE: hw/rtl/kepler_bisection_solver_top.sv
// ----------------------------------------------------------------------------
// kepler_bisection_solver_top
// Solves Kepler's equation by bisection over a grid of eccentric anomalies.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  input     start, busy, mean_phase          start in, busy out
//  result    done, grid_index                 out, one-cycle strobe
//  config    cfg_we, cfg_index, cfg_data      in
//
// Each f(E) evaluation runs through a chain of 3 + 12 + 3 = 18 registered
// stages (front, six Horner cells of two stages each, back), one at a time.
// An item takes 3 evaluations plus one per bisection step.
// Reset clears the controller and loads the config registers with their
// reset values; the bracket, index and function registers are not reset.
// A result beat cannot be held off; busy stays high until its strobe.
// GRID_STEPS must be a power of two.
// ----------------------------------------------------------------------------
module kepler_bisection_solver_top #(
	parameter int GRID_STEPS = kbs_pkg::DEF_GRID_STEPS,
	parameter int SINE_BITS  = kbs_pkg::DEF_SINE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] mean_phase,
	output logic        done,
	output logic [13:0] grid_index,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [27:0] cfg_data
);
	localparam int IW = $clog2(GRID_STEPS + 1);
	localparam int FW = kbs_pkg::FW;

	kbs_pkg::state_t  state_q, state_d;
	kbs_pkg::target_t tgt_q;

	logic [15:0] ecc_q;
	logic [27:0] tol_q;
	logic [30:0] m_q;
	logic [IW-1:0] lo_q, hi_q, mid_q, idx_q, issue_idx;
	logic [IW:0]   mid_sum;
	logic signed [FW-1:0] flo_q, fhi_q, fmid_q;
	logic done_q;
	logic [62:0] mprod;
	logic issue;

	kbs_pkg::tok_t chain [kbs_pkg::HORNER_STEPS+1];
	logic f_valid;
	logic signed [FW-1:0] f;

	logic w_diff, w_lo, w_hi, w_mid, narrow, go_hi, go_lo, fin;
	logic [IW-1:0] fin_idx;
	logic [IW+13:0] idx_ext;

	kbs_front #(.GRID_STEPS(GRID_STEPS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(issue), .idx(issue_idx), .tok(chain[0])
	);

	for (genvar k = 0; k < kbs_pkg::HORNER_STEPS; k++) begin : g_cell
		kbs_cell #(.STEP(k)) u_cell (
			.clk(clk), .arst_n(arst_n), .tin(chain[k]), .tout(chain[k+1])
		);
	end

	kbs_back #(.SINE_BITS(SINE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .tin(chain[kbs_pkg::HORNER_STEPS]),
		.ecc(ecc_q), .m(m_q), .f_valid(f_valid), .f(f)
	);

	assign mprod   = 63'(mean_phase) * 63'(kbs_pkg::TWO_PI_Q28);
	assign mid_sum = (IW+1)'(lo_q) + (IW+1)'(hi_q);

	always_comb begin
		w_diff = kbs_pkg::mag_of((FW+1)'(flo_q) - (FW+1)'(fhi_q)) <= (FW+1)'(tol_q);
		w_lo   = kbs_pkg::mag_of((FW+1)'(flo_q)) <= (FW+1)'(tol_q);
		w_hi   = kbs_pkg::mag_of((FW+1)'(fhi_q)) <= (FW+1)'(tol_q);
		w_mid  = kbs_pkg::mag_of((FW+1)'(fmid_q)) <= (FW+1)'(tol_q);
		narrow = (hi_q - lo_q) <= IW'(1);
		go_hi  = (flo_q != 0) && (fmid_q != 0) && (flo_q[FW-1] != fmid_q[FW-1]);
		go_lo  = (fhi_q != 0) && (fmid_q != 0) && (fhi_q[FW-1] != fmid_q[FW-1]);
		fin     = 1'b1;
		fin_idx = lo_q;
		if (w_diff) begin
			fin_idx = lo_q;
		end else if (w_lo) begin
			fin_idx = lo_q;
		end else if (w_hi) begin
			fin_idx = hi_q;
		end else if (w_mid) begin
			fin_idx = mid_q;
		end else if (narrow) begin
			fin_idx = lo_q;
		end else if (go_hi || go_lo) begin
			fin = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		case (tgt_q)
			kbs_pkg::T_LO:  issue_idx = lo_q;
			kbs_pkg::T_HI:  issue_idx = hi_q;
			default:        issue_idx = mid_sum[IW:1];
		endcase
		unique case (state_q)
			kbs_pkg::S_IDLE:  if (start) state_d = kbs_pkg::S_ISSUE;
			kbs_pkg::S_ISSUE: begin
				issue   = 1'b1;
				state_d = kbs_pkg::S_WAIT;
			end
			kbs_pkg::S_WAIT: begin
				if (f_valid) begin
					state_d = (tgt_q == kbs_pkg::T_MID) ? kbs_pkg::S_CHECK : kbs_pkg::S_ISSUE;
				end
			end
			kbs_pkg::S_CHECK: state_d = fin ? kbs_pkg::S_IDLE : kbs_pkg::S_ISSUE;
			default:          state_d = kbs_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kbs_pkg::S_IDLE;
			done_q  <= 1'b0;
			ecc_q   <= 16'd0;
			tol_q   <= kbs_pkg::TOL_RESET;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == kbs_pkg::S_CHECK) && fin;
			if (cfg_we) begin
				if (cfg_index == kbs_pkg::CFG_ECC) ecc_q <= cfg_data[15:0];
				else tol_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == kbs_pkg::S_IDLE && start) begin
			m_q   <= mprod[62:32];
			lo_q  <= '0;
			hi_q  <= IW'(GRID_STEPS);
			tgt_q <= kbs_pkg::T_LO;
		end
		if (state_q == kbs_pkg::S_ISSUE && tgt_q == kbs_pkg::T_MID) begin
			mid_q <= issue_idx;
		end
		if (state_q == kbs_pkg::S_WAIT && f_valid) begin
			case (tgt_q)
				kbs_pkg::T_LO: begin
					flo_q <= f;
					tgt_q <= kbs_pkg::T_HI;
				end
				kbs_pkg::T_HI: begin
					fhi_q <= f;
					tgt_q <= kbs_pkg::T_MID;
				end
				default: fmid_q <= f;
			endcase
		end
		if (state_q == kbs_pkg::S_CHECK) begin
			idx_q <= fin_idx;
			if (!fin && go_hi) begin
				hi_q  <= mid_q;
				fhi_q <= fmid_q;
			end else if (!fin) begin
				lo_q  <= mid_q;
				flo_q <= fmid_q;
			end
		end
	end

	assign idx_ext    = {14'd0, idx_q};
	assign grid_index = idx_ext[13:0];
	assign done       = done_q;
	assign busy       = state_q != kbs_pkg::S_IDLE;

	a_done_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == kbs_pkg::S_CHECK)
		else $error("result beat without a finished check");
	a_eval_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid |-> state_q == kbs_pkg::S_WAIT)
		else $error("evaluation returned outside of wait");
	a_bracket_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kbs_pkg::S_CHECK |-> lo_q < hi_q)
		else $error("bisection bracket collapsed");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");
endmodule
